// File: sv/cbrpg_pkg.sv
`default_nettype none

package cbrpg_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int PALETTE_DEPTH_DEF = 16;

    // Geometry registers and the shared divider are 13 bits wide
    localparam int DIV_W  = 13;
    localparam int APB_AW = 5;

    // Stream command codes (s_tuser)
    localparam logic [1:0] CMD_PAL_WRITE = 2'd0;
    localparam logic [1:0] CMD_SET_INDEX = 2'd1;
    localparam logic [1:0] CMD_PIXEL     = 2'd2;
    localparam logic [1:0] CMD_NONE      = 2'd3;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_ROW_WIDTH     = 3'd0;
    localparam logic [2:0] REG_COLUMN_COUNT  = 3'd1;
    localparam logic [2:0] REG_GAP_PIXELS    = 3'd2;
    localparam logic [2:0] REG_BACKGROUND    = 3'd3;
    localparam logic [2:0] REG_PALETTE_COUNT = 3'd4;

    // Register reset values
    localparam logic [12:0] ROW_WIDTH_RST     = 13'd640;
    localparam logic [12:0] COLUMN_COUNT_RST  = 13'd8;
    localparam logic [12:0] GAP_PIXELS_RST    = 13'd0;
    localparam logic [23:0] BACKGROUND_RST    = 24'd0;
    localparam logic [4:0]  PALETTE_COUNT_RST = 5'd1;

    typedef struct packed {
        logic [12:0] row_width;
        logic [12:0] column_count;
        logic [12:0] gap_pixels;
        logic [23:0] background_rgb;
        logic [4:0]  palette_count;
    } cfg_t;

    // Controller -> datapath
    typedef struct packed {
        logic pal_wr;
        logic div_row;
        logic div_idx;
        logic div_adv;
        logic row_clear;
        logic row_set;
        logic pixel_step;
        logic ci_from_div;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic pos_zero;
        logic cc_zero;
        logic adv_slow;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/cbrpg_div.sv
`default_nettype none

// Restoring divider, one quotient bit per clock.
module cbrpg_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [cbrpg_pkg::DIV_W-1:0] dividend,
    input  wire logic [cbrpg_pkg::DIV_W-1:0] divisor,
    output logic      [cbrpg_pkg::DIV_W-1:0] quot,
    output logic      [cbrpg_pkg::DIV_W-1:0] rem,
    output logic                             done
);

    localparam int DW = cbrpg_pkg::DIV_W;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

    logic [DW-1:0] quot_reg, quot_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;

    always_comb begin
        shifted   = {rem_reg, quot_reg[DW-1]};
        diff      = shifted - {1'b0, den_reg};
        ge        = shifted >= {1'b0, den_reg};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DW-1:0] : shifted[DW-1:0];
            quot_next = {quot_reg[DW-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: sv/cbrpg_datapath.sv
`default_nettype none

module cbrpg_datapath #(
    parameter int MAX_WIDTH     = cbrpg_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_DEPTH = cbrpg_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cbrpg_pkg::cfg_t       cfg,
    input  wire cbrpg_pkg::ctrl_cmd_t  cmd,
    input  wire logic [7:0]            in_idx,
    input  wire logic [23:0]           in_val,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [23:0]                out_rgb,
    output logic                       out_last,
    output cbrpg_pkg::dp_stat_t        stat
);

    localparam int DW   = cbrpg_pkg::DIV_W;
    localparam int WCAP = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
    localparam int PW   = $clog2(WCAP);
    localparam int IW   = $clog2(PALETTE_DEPTH);

    // Row state
    logic [PW-1:0] pos_reg, pos_next;
    logic [DW-1:0] ss_reg, ss_next;
    logic [DW-2:0] lp_reg, lp_next;
    logic [DW-1:0] off_reg, off_next;
    logic [DW-1:0] sq_reg, sq_next;
    logic [IW-1:0] ci_reg, ci_next;
    logic          bg_reg, bg_next;
    logic          last_reg, last_next;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [23:0]   out_rgb_reg, out_rgb_next;
    logic          out_last_reg, out_last_next;

    // Palette
    logic [23:0]   pal_mem [PALETTE_DEPTH];
    logic [23:0]   rd_data_reg;
    logic          idx_ok;

    // Divider
    logic          div_start;
    logic [DW-1:0] div_dividend, div_divisor, div_quot, div_rem;
    logic          div_done;

    // Pixel step terms
    logic [DW-1:0] eff_w, eff_pc, usable, pos_w, pos_inc, ci_inc, off_inc;
    logic          active, adv, adv_slow, pix_bg, pix_last, off_wrap;
    logic [IW-1:0] ci_fast;

    always_comb begin
        if (cfg.row_width == '0) begin
            eff_w = DW'(1);
        end else if (cfg.row_width > DW'(WCAP)) begin
            eff_w = DW'(WCAP);
        end else begin
            eff_w = cfg.row_width;
        end
        if (cfg.palette_count == '0) begin
            eff_pc = DW'(1);
        end else if (DW'(cfg.palette_count) > DW'(PALETTE_DEPTH)) begin
            eff_pc = DW'(PALETTE_DEPTH);
        end else begin
            eff_pc = DW'(cfg.palette_count);
        end
        usable = (eff_w > cfg.gap_pixels) ? (eff_w - cfg.gap_pixels) : '0;
    end

    always_comb begin
        pos_w    = DW'(pos_reg);
        pos_inc  = pos_w + 1'b1;
        ci_inc   = DW'(ci_reg) + 1'b1;
        off_inc  = off_reg + 1'b1;
        off_wrap = off_inc >= ss_reg;
        active   = (ss_reg != '0) && (pos_w >= DW'(lp_reg));
        adv      = active && (off_reg == '0) && (sq_reg != '0);
        adv_slow = adv && (ci_inc > eff_pc);
        ci_fast  = (ci_inc < eff_pc) ? IW'(ci_inc) : '0;
        pix_bg   = !active || (off_reg < cfg.gap_pixels) || (sq_reg >= cfg.column_count);
        pix_last = pos_inc >= eff_w;
    end

    // Divider operand select
    assign div_start = cmd.div_row | cmd.div_idx | cmd.div_adv;

    always_comb begin
        priority if (cmd.div_row) begin
            div_dividend = usable;
            div_divisor  = cfg.column_count;
        end else if (cmd.div_idx) begin
            div_dividend = DW'(in_idx);
            div_divisor  = eff_pc;
        end else begin
            div_dividend = ci_inc;
            div_divisor  = eff_pc;
        end
    end

    cbrpg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    always_comb begin
        pos_next  = pos_reg;
        ss_next   = ss_reg;
        lp_next   = lp_reg;
        off_next  = off_reg;
        sq_next   = sq_reg;
        ci_next   = ci_reg;
        bg_next   = bg_reg;
        last_next = last_reg;
        if (cmd.row_clear) begin
            ss_next  = '0;
            lp_next  = '0;
            off_next = '0;
            sq_next  = '0;
        end
        if (cmd.row_set) begin
            ss_next  = div_quot;
            lp_next  = div_rem[DW-1:1];
            off_next = '0;
            sq_next  = '0;
        end
        if (cmd.pixel_step) begin
            if (active) begin
                if (off_wrap) begin
                    off_next = '0;
                    if (sq_reg != '1) begin
                        sq_next = sq_reg + 1'b1;
                    end
                end else begin
                    off_next = off_inc;
                end
            end
            if (adv && !adv_slow) begin
                ci_next = ci_fast;
            end
            bg_next   = pix_bg;
            last_next = pix_last;
            pos_next  = pix_last ? '0 : PW'(pos_inc);
        end
        if (cmd.ci_from_div) begin
            ci_next = IW'(div_rem);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !out_ready;
        out_rgb_next   = out_rgb_reg;
        out_last_next  = out_last_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_rgb_next   = bg_reg ? cfg.background_rgb : rd_data_reg;
            out_last_next  = last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            ss_reg        <= '0;
            lp_reg        <= '0;
            off_reg       <= '0;
            sq_reg        <= '0;
            ci_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            ss_reg        <= ss_next;
            lp_reg        <= lp_next;
            off_reg       <= off_next;
            sq_reg        <= sq_next;
            ci_reg        <= ci_next;
            out_valid_reg <= out_valid_next;
        end
        bg_reg       <= bg_next;
        last_reg     <= last_next;
        out_rgb_reg  <= out_rgb_next;
        out_last_reg <= out_last_next;
    end

    // Palette: one write port, registered read that follows the next index
    assign idx_ok = {1'b0, in_idx} < 9'(PALETTE_DEPTH);

    always_ff @(posedge aclk) begin
        if (cmd.pal_wr && idx_ok) begin
            pal_mem[in_idx[IW-1:0]] <= in_val;
        end
        rd_data_reg <= pal_mem[ci_next];
    end

    assign out_valid = out_valid_reg;
    assign out_rgb   = out_rgb_reg;
    assign out_last  = out_last_reg;

    always_comb begin
        stat.pos_zero = pos_reg == '0;
        stat.cc_zero  = cfg.column_count == '0;
        stat.adv_slow = adv_slow;
        stat.div_done = div_done;
        stat.out_free = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

// File: sv/cbrpg_ctrl.sv
`default_nettype none

module cbrpg_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  wire logic [1:0]           in_cmd,
    input  wire cbrpg_pkg::dp_stat_t  stat,
    output logic                      in_ready,
    output cbrpg_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_PIXEL   = 6'b000010,
        ST_DIV_ROW = 6'b000100,
        ST_DIV_IDX = 6'b001000,
        ST_DIV_ADV = 6'b010000,
        ST_EMIT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE) && stat.out_free;
        accept     = in_valid && in_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        cbrpg_pkg::CMD_PAL_WRITE: begin
                            cmd.pal_wr = 1'b1;
                        end
                        cbrpg_pkg::CMD_SET_INDEX: begin
                            cmd.div_idx = 1'b1;
                            state_next  = ST_DIV_IDX;
                        end
                        cbrpg_pkg::CMD_PIXEL: begin
                            if (stat.pos_zero && stat.cc_zero) begin
                                cmd.row_clear = 1'b1;
                                state_next    = ST_PIXEL;
                            end else if (stat.pos_zero) begin
                                cmd.div_row = 1'b1;
                                state_next  = ST_DIV_ROW;
                            end else if (stat.adv_slow) begin
                                cmd.pixel_step = 1'b1;
                                cmd.div_adv    = 1'b1;
                                state_next     = ST_DIV_ADV;
                            end else begin
                                cmd.pixel_step = 1'b1;
                                state_next     = ST_EMIT;
                            end
                        end
                        cbrpg_pkg::CMD_NONE: begin
                        end
                    endcase
                end
            end
            ST_PIXEL: begin
                cmd.pixel_step = 1'b1;
                if (stat.adv_slow) begin
                    cmd.div_adv = 1'b1;
                    state_next  = ST_DIV_ADV;
                end else begin
                    state_next  = ST_EMIT;
                end
            end
            ST_DIV_ROW: begin
                if (stat.div_done) begin
                    cmd.row_set = 1'b1;
                    state_next  = ST_PIXEL;
                end
            end
            ST_DIV_IDX: begin
                if (stat.div_done) begin
                    cmd.ci_from_div = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_DIV_ADV: begin
                if (stat.div_done) begin
                    cmd.ci_from_div = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.out_load = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/checkerboard_row_pattern_generator.sv
// Checkerboard row pattern generator.
// Input stream (s_): one transaction per command; s_tuser is the command, s_tdata
// carries the palette entry/index and color. Commands: palette write, set color
// index (taken modulo the palette count), next pixel. Only next pixel gives a
// result transaction on the m_ stream: the pixel color in m_tdata, m_tlast on
// the last pixel of the row. Geometry and the background color (palette colors
// come on the stream) live in APB registers, which the user must write only
// while the block is idle; the block itself does not enforce this. A palette
// write is stored as it is accepted. Set index runs the 13-step shared restoring
// divider, then hands the remainder to the index. A pixel is accepted and
// stepped, then the output register is loaded from the registered palette read.
// The first pixel of a row first runs the square size / remainder division
// (none when the column count is zero); a pixel whose palette advance cannot be
// wrapped by one compare (palette count at or below the current index) also runs the divider.
// Reset (aresetn low, synchronous) restores register defaults, clears index,
// position and row counters; palette contents stay undefined until written.
// A stalled receiver holds the result in the output register; the next command
// is taken once that register is free or is being emptied in the same cycle.
`default_nettype none

module checkerboard_row_pattern_generator #(
    parameter int MAX_WIDTH     = cbrpg_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_DEPTH = cbrpg_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // APB configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cbrpg_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    // Command stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,   // [7:0] entry_index, [31:8] color_value
    input  wire logic [1:0]                    s_tuser,   // [1:0] command
    // Pixel stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [23:0]                   m_tdata,   // [23:0] pixel_rgb
    output logic                               m_tlast    // last_in_row
);

    cbrpg_pkg::cfg_t      cfg_reg, cfg_next;
    cbrpg_pkg::ctrl_cmd_t cmd;
    cbrpg_pkg::dp_stat_t  stat;
    logic                 cfg_wr;
    logic [2:0]           reg_sel;

    // Register file: index is the word address
    assign pready  = 1'b1;
    assign reg_sel = paddr[cbrpg_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            unique case (reg_sel)
                cbrpg_pkg::REG_ROW_WIDTH:     cfg_next.row_width      = pwdata[12:0];
                cbrpg_pkg::REG_COLUMN_COUNT:  cfg_next.column_count   = pwdata[12:0];
                cbrpg_pkg::REG_GAP_PIXELS:    cfg_next.gap_pixels     = pwdata[12:0];
                cbrpg_pkg::REG_BACKGROUND:    cfg_next.background_rgb = pwdata[23:0];
                cbrpg_pkg::REG_PALETTE_COUNT: cfg_next.palette_count  = pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            cbrpg_pkg::REG_ROW_WIDTH:     prdata = 32'(cfg_reg.row_width);
            cbrpg_pkg::REG_COLUMN_COUNT:  prdata = 32'(cfg_reg.column_count);
            cbrpg_pkg::REG_GAP_PIXELS:    prdata = 32'(cfg_reg.gap_pixels);
            cbrpg_pkg::REG_BACKGROUND:    prdata = 32'(cfg_reg.background_rgb);
            cbrpg_pkg::REG_PALETTE_COUNT: prdata = 32'(cfg_reg.palette_count);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_width      <= cbrpg_pkg::ROW_WIDTH_RST;
            cfg_reg.column_count   <= cbrpg_pkg::COLUMN_COUNT_RST;
            cfg_reg.gap_pixels     <= cbrpg_pkg::GAP_PIXELS_RST;
            cfg_reg.background_rgb <= cbrpg_pkg::BACKGROUND_RST;
            cfg_reg.palette_count  <= cbrpg_pkg::PALETTE_COUNT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: decodes commands, runs the divider, paces the output register
    cbrpg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    // Row counters, palette memory, divider and output register
    cbrpg_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .in_idx    (s_tdata[7:0]),
        .in_val    (s_tdata[31:8]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_rgb   (m_tdata),
        .out_last  (m_tlast),
        .stat      (stat)
    );

    // A new command is only offered when the output register can take a pixel
    a_ready_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("command accepted while output register blocked");

    // An accepted pixel transaction always moves the sequencer out of idle, holding off the input
    a_pixel_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == cbrpg_pkg::CMD_PIXEL)) |=> !s_tready)
        else $error("pixel command did not hold off the input");

    // A fresh result is loaded only from the emit step, never from idle
    a_emit_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while sequencer was idle");

endmodule

`default_nettype wire

// File: bench/checkerboard_row_pattern_generator_tb.sv
// Self-checking bench for the checkerboard row generator.
// Command transactions go in on the s_ stream and the block's pixel transactions come
// back on the m_ stream. A local row model runs on every accepted command transaction
// and queues any pixel it should produce; the monitor pops one entry per pixel.
module checkerboard_row_pattern_generator_tb;

    localparam int ITEM_TARGET  = 1550;  // stop random stimulus around here
    localparam int QUIET_CYCLES = 64;    // outlasts set index + row start + wrap divides
    localparam int HOLD_CYCLES  = 400;   // long receiver back-pressure
    localparam bit ROW_ITEM     = 1'b0;
    localparam bit ROW_CFG      = 1'b1;

    // ---------------------------------------------------------------- DUT I/O
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [cbrpg_pkg::APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;  // [7:0] entry_index, [31:8] color_value
    logic [1:0]  s_tuser  = cbrpg_pkg::CMD_NONE;  // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [23:0] pixel_rgb
    logic        m_tlast;        // last_in_row

    checkerboard_row_pattern_generator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------- row model
    typedef struct packed {
        logic [23:0] rgb;
        logic        last;
    } pixel_t;

    pixel_t pending_pixels [$];

    // register mirror, reset values from the package
    logic [12:0] cfg_row_width     = cbrpg_pkg::ROW_WIDTH_RST;
    logic [12:0] cfg_columns       = cbrpg_pkg::COLUMN_COUNT_RST;
    logic [12:0] cfg_gap           = cbrpg_pkg::GAP_PIXELS_RST;
    logic [23:0] cfg_background    = cbrpg_pkg::BACKGROUND_RST;
    logic [4:0]  cfg_palette_count = cbrpg_pkg::PALETTE_COUNT_RST;

    // row state; palette is filled before any pixel can read it
    logic [23:0] pal_mem [cbrpg_pkg::PALETTE_DEPTH_DEF];
    logic [3:0]  cur_index = '0;
    logic [11:0] pix_pos   = '0;
    logic [12:0] sq_size   = '0;
    logic [11:0] pad_left  = '0;
    logic [12:0] off_cnt   = '0;
    logic [12:0] sq_cnt    = '0;

    task automatic predict_command(input logic [1:0] cmd, input logic [7:0] idx,
                                   input logic [23:0] val);
        int unsigned w, npal, pos, usable;
        bit          bg;
        pixel_t      px;
        // out-of-range register values are clamped, not wrapped
        w = (cfg_row_width == 0) ? 1 :
            (cfg_row_width > cbrpg_pkg::MAX_WIDTH_DEF) ? cbrpg_pkg::MAX_WIDTH_DEF :
            cfg_row_width;
        npal = (cfg_palette_count == 0) ? 1 :
               (cfg_palette_count > cbrpg_pkg::PALETTE_DEPTH_DEF) ?
               cbrpg_pkg::PALETTE_DEPTH_DEF : cfg_palette_count;
        case (cmd)
            cbrpg_pkg::CMD_PAL_WRITE: begin
                if (idx < cbrpg_pkg::PALETTE_DEPTH_DEF) pal_mem[idx[3:0]] = val;
            end
            cbrpg_pkg::CMD_SET_INDEX: begin
                cur_index = 4'(idx % npal);
            end
            cbrpg_pkg::CMD_PIXEL: begin
                pos = pix_pos;
                bg  = 1'b1;
                // square size and pad are latched only at row start
                if (pos == 0) begin
                    usable = (w > cfg_gap) ? w - cfg_gap : 0;
                    if (cfg_columns == 0) begin
                        sq_size  = '0;
                        pad_left = '0;
                    end else begin
                        sq_size  = 13'(usable / cfg_columns);
                        pad_left = 12'((usable % cfg_columns) / 2);
                    end
                    off_cnt = '0;
                    sq_cnt  = '0;
                end
                // zero square width: whole row background, index frozen
                if (sq_size != 0 && pos >= pad_left) begin
                    if (off_cnt == 0 && sq_cnt != 0)
                        cur_index = 4'((cur_index + 1) % npal);
                    bg = (off_cnt < cfg_gap) || (sq_cnt >= cfg_columns);
                    if (off_cnt + 1 >= sq_size) begin
                        off_cnt = '0;
                        if (sq_cnt != 13'h1FFF) sq_cnt = sq_cnt + 1'b1;
                    end else begin
                        off_cnt = off_cnt + 1'b1;
                    end
                end
                px.rgb  = bg ? cfg_background : pal_mem[cur_index];
                px.last = (pos + 1 >= w);
                pix_pos = px.last ? '0 : 12'(pos + 1);
                pending_pixels.push_back(px);
            end
            default: ;  // unknown command: dropped, no pixel
        endcase
    endtask

    // ---------------------------------------------------------------- drivers
    bit          no_idle       = 1'b0;  // both sides run without gaps
    int unsigned hold_requests = 0;     // bumped by the sender, served by the receiver
    int          items_sent    = 0;
    int          mismatch_count = 0;

    // One command transaction. Called at a falling edge on which s_tvalid is not yet
    // driven; returns at the next falling edge after the handshake.
    task automatic send_command(input logic [1:0] cmd, input logic [7:0] idx,
                                input logic [23:0] val, input bit fixed, input pixel_t typed);
        while (!no_idle && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_command(cmd, idx, val);
        // directed rows with a hand-computed pixel replace the model's entry
        if (fixed) pending_pixels[$] = typed;
        items_sent++;
        @(negedge aclk);
    endtask

    // Stop offering, wait for every queued pixel, then let slow internal work
    // (set index divides, row start) finish before touching registers.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    // Setup + access; the register takes the value on the edge with pready high.
    task automatic apb_write(input logic [2:0] sel, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (sel)
            cbrpg_pkg::REG_ROW_WIDTH:     cfg_row_width     = data[12:0];
            cbrpg_pkg::REG_COLUMN_COUNT:  cfg_columns       = data[12:0];
            cbrpg_pkg::REG_GAP_PIXELS:    cfg_gap           = data[12:0];
            cbrpg_pkg::REG_BACKGROUND:    cfg_background    = data[23:0];
            cbrpg_pkg::REG_PALETTE_COUNT: cfg_palette_count = data[4:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Receiver: ~6% random stalls, none while no_idle, and one long hold-off
    // counted here so the block backs up into its input.
    initial begin
        int unsigned holds_done;
        holds_done = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_done) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= no_idle || ($urandom_range(99) >= 6);
        end
    end

    // ---------------------------------------------------------------- monitor
    pixel_t got_px, want_px;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_px = '{rgb: m_tdata, last: m_tlast};
            if (pending_pixels.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected pixel transaction: rgb %h last %b",
                             got_px.rgb, got_px.last);
                mismatch_count++;
            end else begin
                want_px = pending_pixels.pop_front();
                if (got_px.rgb !== want_px.rgb || got_px.last !== want_px.last) begin
                    if (mismatch_count < 10)
                        $display("pixel mismatch: rgb exp %h got %h, last exp %b got %b",
                                 want_px.rgb, got_px.rgb, want_px.last, got_px.last);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- directed rows
    typedef struct packed {
        logic        kind;       // ROW_ITEM or ROW_CFG
        logic [2:0]  reg_sel;
        logic [31:0] reg_val;
        logic [1:0]  cmd;
        logic [7:0]  idx;
        logic [23:0] val;
        logic        fixed;      // pixel typed in below
        logic [23:0] want_rgb;
        logic        want_last;
    } dir_row_t;

    localparam int N_DIRECTED = 38;

    // palette entry 0 is 24'h102030 after the fill
    dir_row_t directed_rows [N_DIRECTED] = '{
        // reset geometry: 640 wide, 8 squares of 80, first square shows entry 0
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      1, 24'h102030, 0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_NONE,      8'd255, 24'hFFFFFF, 0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PAL_WRITE, 8'd255, 24'hFFFFFF, 0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_SET_INDEX, 8'd255, 24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      1, 24'h102030, 0},
        '{ROW_CFG,  cbrpg_pkg::REG_BACKGROUND, 32'hFFFFFF,
          cbrpg_pkg::CMD_NONE,      8'd0,   24'h0,      0, 24'h0,      0},
        // width 0 acts as 1: current pixel is past the end and closes the row
        '{ROW_CFG,  cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_NONE,      8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      1, 24'h102030, 1},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      1, 24'hFFFFFF, 1},
        // width above max clamps; zero columns gives an all-background row
        '{ROW_CFG,  cbrpg_pkg::REG_ROW_WIDTH, 32'd8191,
          cbrpg_pkg::CMD_NONE,      8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_CFG,  cbrpg_pkg::REG_COLUMN_COUNT, 32'd0,
          cbrpg_pkg::CMD_NONE,      8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      1, 24'hFFFFFF, 0},
        '{ROW_CFG,  cbrpg_pkg::REG_COLUMN_COUNT, 32'd8191,
          cbrpg_pkg::CMD_NONE,      8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_CFG,  cbrpg_pkg::REG_PALETTE_COUNT, 32'd31,
          cbrpg_pkg::CMD_NONE,      8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_SET_INDEX, 8'd255, 24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      1, 24'hFFFFFF, 0},
        // gap wider than the row, more columns than pixels
        '{ROW_CFG,  cbrpg_pkg::REG_GAP_PIXELS, 32'd8191,
          cbrpg_pkg::CMD_NONE,      8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_CFG,  cbrpg_pkg::REG_ROW_WIDTH, 32'd2,
          cbrpg_pkg::CMD_NONE,      8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      1, 24'hFFFFFF, 1},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      1, 24'hFFFFFF, 0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      1, 24'hFFFFFF, 1},
        // 12 wide, 3 squares of 3 with 1 gap pixel, left pad 1, one partial square
        // past the last column; index 15 above a palette of 3 wraps on first advance
        '{ROW_CFG,  cbrpg_pkg::REG_ROW_WIDTH, 32'd12,
          cbrpg_pkg::CMD_NONE,      8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_CFG,  cbrpg_pkg::REG_COLUMN_COUNT, 32'd3,
          cbrpg_pkg::CMD_NONE,      8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_CFG,  cbrpg_pkg::REG_GAP_PIXELS, 32'd1,
          cbrpg_pkg::CMD_NONE,      8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_CFG,  cbrpg_pkg::REG_PALETTE_COUNT, 32'd3,
          cbrpg_pkg::CMD_NONE,      8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_CFG,  cbrpg_pkg::REG_BACKGROUND, 32'd0,
          cbrpg_pkg::CMD_NONE,      8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      0, 24'h0,      0},
        '{ROW_ITEM, cbrpg_pkg::REG_ROW_WIDTH, 32'd0,
          cbrpg_pkg::CMD_PIXEL,     8'd0,   24'h0,      0, 24'h0,      0}
    };

    // ---------------------------------------------------------------- main sequence
    initial begin
        logic [1:0]  cmd;
        logic [7:0]  idx;
        logic [23:0] val;
        logic [31:0] wval;
        int unsigned pick;
        int          phase;

        // single reset at start
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // palette contents are undefined after reset: write every entry first
        for (int i = 0; i < cbrpg_pkg::PALETTE_DEPTH_DEF; i++)
            send_command(cbrpg_pkg::CMD_PAL_WRITE, 8'(i),
                         24'h102030 + 24'(i) * 24'h0F0F0F, 1'b0, '0);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_quiet();
                apb_write(directed_rows[i].reg_sel, directed_rows[i].reg_val);
            end else begin
                send_command(directed_rows[i].cmd, directed_rows[i].idx,
                             directed_rows[i].val, directed_rows[i].fixed,
                             '{rgb: directed_rows[i].want_rgb,
                               last: directed_rows[i].want_last});
            end
        end

        // Random phases: quiet point, new register mix, then a burst of commands.
        // Mostly pixels so rows run to their end; some palette/index/unknown noise.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            phase++;
            wait_quiet();
            no_idle = (phase >= 4 && phase < 8);

            if ($urandom_range(9) < 7) begin
                pick = $urandom_range(19);
                case (pick)
                    0:       wval = 32'd0;
                    1:       wval = 32'(cbrpg_pkg::MAX_WIDTH_DEF);
                    2:       wval = 32'($urandom_range(8191, cbrpg_pkg::MAX_WIDTH_DEF + 1));
                    3:       wval = 32'd1;
                    default: wval = 32'($urandom_range(48, 2));
                endcase
                apb_write(cbrpg_pkg::REG_ROW_WIDTH, wval);
            end
            if ($urandom_range(9) < 7) begin
                pick = $urandom_range(19);
                case (pick)
                    0:       wval = 32'd0;
                    1:       wval = 32'd8191;
                    2:       wval = 32'($urandom_range(8191, 64));
                    default: wval = 32'($urandom_range(8, 1));
                endcase
                apb_write(cbrpg_pkg::REG_COLUMN_COUNT, wval);
            end
            if ($urandom_range(9) < 7) begin
                pick = $urandom_range(9);
                if (pick < 6)      wval = 32'd0;
                else if (pick < 9) wval = 32'($urandom_range(4, 0));
                else               wval = 32'($urandom_range(8191, 0));
                apb_write(cbrpg_pkg::REG_GAP_PIXELS, wval);
            end
            if ($urandom_range(9) < 7)
                apb_write(cbrpg_pkg::REG_BACKGROUND, 32'($urandom) & 32'hFFFFFF);
            if ($urandom_range(9) < 7)
                apb_write(cbrpg_pkg::REG_PALETTE_COUNT, 32'($urandom_range(31, 0)));

            // one long receiver stall while commands keep coming
            if (phase == 9) hold_requests++;

            repeat ($urandom_range(100, 20)) begin
                pick = $urandom_range(99);
                idx  = 8'($urandom);
                val  = 24'($urandom);
                if (pick < 78) begin
                    cmd = cbrpg_pkg::CMD_PIXEL;
                end else if (pick < 88) begin
                    cmd = cbrpg_pkg::CMD_PAL_WRITE;
                    if ($urandom_range(4) != 0) idx = 8'($urandom_range(15));
                end else if (pick < 96) begin
                    cmd = cbrpg_pkg::CMD_SET_INDEX;
                end else begin
                    cmd = cbrpg_pkg::CMD_NONE;
                end
                send_command(cmd, idx, val, 1'b0, '0);
            end
        end

        no_idle = 1'b0;
        wait_quiet();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #1000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
sv/cbrpg_pkg.sv
sv/cbrpg_div.sv
sv/cbrpg_datapath.sv
sv/cbrpg_ctrl.sv
sv/checkerboard_row_pattern_generator.sv
bench/checkerboard_row_pattern_generator_tb.sv
